// File: hdl/nps_pkg.sv
// Shared types and constants for the nearest point search block.
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam int INDEX_BITS    = 10;
   localparam int DIST_BITS     = 50;
   localparam int RSP_DATA_BITS = 64;

   localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_APPEND,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
   } cmd_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } back_state_type;

endpackage
`default_nettype wire

// File: hdl/nps_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] addr,
   input  wire logic [WIDTH-1:0]     wdata,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hdl/nps_front.sv
// Input side: accepts transfers, classifies the kind and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module nps_front #(
   parameter int COORD_BITS = 24,
   localparam int DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [DATA_BITS-1:0]       req_tdata,
   input  wire logic [1:0]                 req_tuser,
   output nps_pkg::cmd_ctl_type            cmd_ctl,
   output logic      [3*COORD_BITS-1:0]    cmd_coords,
   input  wire logic                       cmd_pop
);
   import nps_pkg::*;

   localparam int PB = 3 * COORD_BITS;

   cmd_kind_type   kind_ff [2];
   logic [PB-1:0]  data_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     fill_ff, fill_in;
   logic           push;
   logic           known;
   cmd_kind_type   kind_in;

   always_comb begin
      known   = 1'b1;
      kind_in = CMD_CLEAR;
      case (req_tuser)
         KIND_CLEAR:  kind_in = CMD_CLEAR;
         KIND_APPEND: kind_in = CMD_APPEND;
         KIND_QUERY:  kind_in = CMD_QUERY;
         default:     known   = 1'b0;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready && known;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff] <= kind_in;
         data_ff[wr_ptr_ff] <= req_tdata[PB-1:0];
      end
   end

   assign cmd_ctl.valid = (fill_ff != 2'd0);
   assign cmd_ctl.kind  = kind_ff[rd_ptr_ff];
   assign cmd_coords    = data_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// File: hdl/nps_back.sv
// Execution side: point table, distance pipeline, best-point tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module nps_back #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire nps_pkg::cmd_ctl_type          cmd_ctl,
   input  wire logic [3*COORD_BITS-1:0]       cmd_coords,
   output logic                               cmd_pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [nps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tuser
);
   import nps_pkg::*;

   localparam int CB       = COORD_BITS;
   localparam int PB       = 3 * CB;
   localparam int AW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW       = $clog2(MAX_POINTS + 1);
   localparam int SQ_BITS  = 2 * CB;
   localparam int SUM_BITS = 2 * CB + 2;
   localparam int EXT_BITS = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS + 1;
   localparam int PAD_BITS = RSP_DATA_BITS - INDEX_BITS - DIST_BITS;

   back_state_type state_ff, state_in;

   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic signed [CB-1:0] qx_ff, qy_ff, qz_ff;

   logic                 rd_v_ff, rd_last_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic                 df_v_ff, df_last_ff;
   logic [AW-1:0]        df_idx_ff;
   logic [CB-1:0]        dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic                 sq_v_ff, sq_last_ff;
   logic [AW-1:0]        sq_idx_ff;
   logic [SQ_BITS-1:0]   sqx_ff, sqy_ff, sqz_ff;
   logic                 sm_v_ff, sm_last_ff;
   logic [AW-1:0]        sm_idx_ff;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;

   logic                 best_found_ff, best_found_in;
   logic [DIST_BITS-1:0] best_d_ff, best_d_in;
   logic [AW-1:0]        best_idx_ff, best_idx_in;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_empty_ff, out_empty_in;
   logic [INDEX_BITS-1:0] out_idx_ff, out_idx_in;
   logic [DIST_BITS-1:0]  out_dist_ff, out_dist_in;

   logic                 out_free;
   logic                 issue, scan_last, start_query, load_empty, load_result;
   logic                 ram_we;
   logic [AW-1:0]        ram_addr;
   logic [PB-1:0]        ram_rdata;
   logic                 table_full;
   logic [EXT_BITS-1:0]  sum_ext;
   logic [DIST_BITS-1:0] sat_d;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign table_full = (count_ff == CW'(MAX_POINTS));
   assign scan_last  = ((CW'(addr_ff) + CW'(1)) == count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_ctl.valid && cmd_ctl.kind == CMD_QUERY && out_free &&
                count_ff != '0) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sm_v_ff && sm_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop     = 1'b0;
      ram_we      = 1'b0;
      issue       = 1'b0;
      start_query = 1'b0;
      load_empty  = 1'b0;
      load_result = 1'b0;
      count_in    = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_ctl.valid) begin
               case (cmd_ctl.kind)
                  CMD_CLEAR: begin
                     cmd_pop  = 1'b1;
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     cmd_pop = 1'b1;
                     if (!table_full) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_QUERY: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        if (count_ff == '0) begin
                           load_empty = 1'b1;
                        end else begin
                           start_query = 1'b1;
                        end
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         ST_SCAN:   issue       = 1'b1;
         ST_FINISH: load_result = 1'b1;
         default: begin
         end
      endcase
   end

   assign ram_addr = ram_we ? count_ff[AW-1:0] : addr_ff;
   assign addr_in  = start_query ? '0 : (issue ? addr_ff + AW'(1) : addr_ff);

   nps_ram #(
      .WIDTH(PB),
      .DEPTH(MAX_POINTS)
   ) u_point_ram (
      .clock(clock),
      .we(ram_we),
      .addr(ram_addr),
      .wdata(cmd_coords),
      .rdata(ram_rdata)
   );

   always_comb begin
      logic signed [CB:0] ex, ey, ez;
      ex = {ram_rdata[CB-1], ram_rdata[CB-1:0]} - {qx_ff[CB-1], qx_ff};
      ey = {ram_rdata[2*CB-1], ram_rdata[2*CB-1:CB]} - {qy_ff[CB-1], qy_ff};
      ez = {ram_rdata[3*CB-1], ram_rdata[3*CB-1:2*CB]} - {qz_ff[CB-1], qz_ff};
      dx_in = ex[CB] ? CB'(-ex) : ex[CB-1:0];
      dy_in = ey[CB] ? CB'(-ey) : ey[CB-1:0];
      dz_in = ez[CB] ? CB'(-ez) : ez[CB-1:0];
   end

   assign sum_in  = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff) + SUM_BITS'(sqz_ff);
   assign sum_ext = EXT_BITS'(sum_ff);
   assign sat_d   = (sum_ext > EXT_BITS'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_BITS-1:0];

   always_comb begin
      best_found_in = best_found_ff;
      best_d_in     = best_d_ff;
      best_idx_in   = best_idx_ff;
      if (start_query) begin
         best_found_in = 1'b0;
      end else if (sm_v_ff && (!best_found_ff || sat_d < best_d_ff)) begin
         best_found_in = 1'b1;
         best_d_in     = sat_d;
         best_idx_in   = sm_idx_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_empty_in = out_empty_ff;
      out_idx_in   = out_idx_ff;
      out_dist_in  = out_dist_ff;
      if (load_empty) begin
         out_valid_in = 1'b1;
         out_empty_in = 1'b1;
         out_idx_in   = '0;
         out_dist_in  = '0;
      end else if (load_result) begin
         out_valid_in = 1'b1;
         out_empty_in = 1'b0;
         out_idx_in   = INDEX_BITS'(best_idx_ff);
         out_dist_in  = best_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_v_ff       <= 1'b0;
         df_v_ff       <= 1'b0;
         sq_v_ff       <= 1'b0;
         sm_v_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_v_ff       <= issue;
         df_v_ff       <= rd_v_ff;
         sq_v_ff       <= df_v_ff;
         sm_v_ff       <= sq_v_ff;
         best_found_ff <= best_found_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      if (start_query) begin
         qx_ff <= cmd_coords[CB-1:0];
         qy_ff <= cmd_coords[2*CB-1:CB];
         qz_ff <= cmd_coords[3*CB-1:2*CB];
      end
      rd_last_ff  <= scan_last;
      rd_idx_ff   <= addr_ff;
      df_last_ff  <= rd_last_ff;
      df_idx_ff   <= rd_idx_ff;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      sq_last_ff  <= df_last_ff;
      sq_idx_ff   <= df_idx_ff;
      sqx_ff      <= SQ_BITS'(dx_ff) * SQ_BITS'(dx_ff);
      sqy_ff      <= SQ_BITS'(dy_ff) * SQ_BITS'(dy_ff);
      sqz_ff      <= SQ_BITS'(dz_ff) * SQ_BITS'(dz_ff);
      sm_last_ff  <= sq_last_ff;
      sm_idx_ff   <= sq_idx_ff;
      sum_ff      <= sum_in;
      best_d_ff   <= best_d_in;
      best_idx_ff <= best_idx_in;
      out_empty_ff <= out_empty_in;
      out_idx_ff   <= out_idx_in;
      out_dist_ff  <= out_dist_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, out_dist_ff, out_idx_ff};
   assign rsp_tuser  = out_empty_ff;

endmodule
`default_nettype wire

// File: hdl/nearest_point_search.sv
// Top level of the brute-force 3-D nearest point search block.
//
// Channel  Direction  Transfer carries
// req      in         tuser: kind; tdata: coord_x, coord_y, coord_z
// rsp      out        tdata: nearest_index, nearest_distance_sq; tuser: table_empty
//
// Clear and append items are executed by the execution side while it is idle.
// During a query one stored point is read from the single-port point RAM each cycle,
// followed by the drain of the distance pipeline. Reset clears the point count, the
// command queue and the valid flag of the result register; the point RAM is not
// cleared. The two-entry command queue accepts while a query runs until it holds
// two commands. A query that finds a result still waiting stays at the head of the
// queue, so a held-off rsp_tready backs up to req_tready.
`timescale 1ns / 1ps
`default_nettype none
module nearest_point_search #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 24,
   localparam int REQ_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // coord_x, coord_y, coord_z, zero padding
   input  wire logic [REQ_DATA_BITS-1:0]          req_tdata,
   // kind
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // nearest_index, nearest_distance_sq, zero padding
   output logic [nps_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // table_empty
   output logic                                   rsp_tuser
);
   import nps_pkg::*;

   cmd_ctl_type               cmd_ctl;
   logic [3*COORD_BITS-1:0]   cmd_coords;
   logic                      cmd_pop;

   nps_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .cmd_ctl(cmd_ctl),
      .cmd_coords(cmd_coords),
      .cmd_pop(cmd_pop)
   );

   nps_back #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_ctl(cmd_ctl),
      .cmd_coords(cmd_coords),
      .cmd_pop(cmd_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule
`default_nettype wire

// File: tb/tb_nearest_point_search.sv
// Self-checking testbench for the nearest point search block.
`timescale 1ns / 1ps
module tb_nearest_point_search;
   import nps_pkg::*;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 24;
   localparam int REQ_BITS = 3 * COORD_BITS;
   localparam int ITEM_TARGET = 580;
   localparam int HOLD_CYCLES = 300;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [23:0] C_MIN = 24'h800000;
   localparam logic [23:0] C_MAX = 24'h7FFFFF;
   localparam logic [23:0] C_ZERO = 24'h000000;
   localparam logic [23:0] C_ONE = 24'h000001;
   localparam logic [23:0] C_NEG1 = 24'hFFFFFF;
   localparam logic [DIST_BITS-1:0] MAX_DIST_SQ = 50'd844424829468675;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic [DIST_BITS-1:0]  dist_sq;
      logic                  empty;
   } nearest_result_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [23:0]           x;
      logic [23:0]           y;
      logic [23:0]           z;
      logic                  fixed;
      logic [INDEX_BITS-1:0] index;
      logic [DIST_BITS-1:0]  dist_sq;
      logic                  empty;
   } stim_row_type;

   typedef enum { COORD_FULL, COORD_NEAR, COORD_EDGE } coord_style_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;

   logic signed [23:0] store_x [MAX_POINTS];
   logic signed [23:0] store_y [MAX_POINTS];
   logic signed [23:0] store_z [MAX_POINTS];
   int stored_count = 0;
   nearest_result_type nearest_expected [$];

   int mismatch_count = 0;
   int sent_count = 0;
   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;
   bit hold_request = 1'b0;

   stim_row_type directed_rows [21] = '{
      '{KIND_QUERY,  C_ZERO, C_ZERO, C_ZERO, 1'b1, 10'd0, 50'd0, 1'b1},
      '{KIND_UNUSED, C_MAX, C_MIN, C_MAX, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_APPEND, C_MIN, C_MIN, C_MIN, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_MAX, C_MAX, C_MAX, 1'b1, 10'd0, MAX_DIST_SQ, 1'b0},
      '{KIND_APPEND, C_MAX, C_MAX, C_MAX, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_MAX, C_MAX, C_MAX, 1'b1, 10'd1, 50'd0, 1'b0},
      '{KIND_APPEND, C_ZERO, C_ZERO, C_ZERO, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_APPEND, C_ZERO, C_ZERO, C_ZERO, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_ZERO, C_ZERO, C_ZERO, 1'b1, 10'd2, 50'd0, 1'b0},
      '{KIND_APPEND, C_ONE, C_NEG1, C_ZERO, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_ONE, C_ZERO, C_ZERO, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_APPEND, 24'h555555, 24'hAAAAAA, 24'h5A5A5A, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  24'hAAAAAA, 24'h555555, 24'hA5A5A5, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_UNUSED, 24'h123456, 24'hFEDCBA, 24'h0F0F0F, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_MIN, C_MAX, C_ZERO, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_CLEAR,  C_NEG1, C_NEG1, C_NEG1, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_ONE, C_ONE, C_ONE, 1'b1, 10'd0, 50'd0, 1'b1},
      '{KIND_APPEND, 24'd100, -24'sd200, 24'd300, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_QUERY,  C_NEG1, C_NEG1, C_NEG1, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_CLEAR,  C_ZERO, C_ZERO, C_ZERO, 1'b0, 10'd0, 50'd0, 1'b0},
      '{KIND_APPEND, C_MIN, C_MAX, C_MIN, 1'b0, 10'd0, 50'd0, 1'b0}
   };

   nearest_point_search #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [DIST_BITS-1:0] squared_distance(input int n,
         input logic signed [23:0] qx, input logic signed [23:0] qy,
         input logic signed [23:0] qz);
      longint dx, dy, dz;
      dx = longint'(store_x[n]) - longint'(qx);
      dy = longint'(store_y[n]) - longint'(qy);
      dz = longint'(store_z[n]) - longint'(qz);
      return DIST_BITS'(dx * dx + dy * dy + dz * dz);
   endfunction

   // Updates the point table and returns 1 when the item yields a result.
   function automatic bit search_update(input logic [1:0] kind,
         input logic signed [23:0] qx, input logic signed [23:0] qy,
         input logic signed [23:0] qz, output nearest_result_type found);
      logic [DIST_BITS-1:0] d;
      found = '0;
      case (kind)
         KIND_CLEAR: stored_count = 0;
         KIND_APPEND: begin
            if (stored_count < MAX_POINTS) begin
               store_x[stored_count] = qx;
               store_y[stored_count] = qy;
               store_z[stored_count] = qz;
               stored_count++;
            end
         end
         KIND_QUERY: begin
            if (stored_count == 0) begin
               found.empty = 1'b1;
               return 1'b1;
            end
            found.dist_sq = squared_distance(0, qx, qy, qz);
            for (int n = 1; n < stored_count; n++) begin
               d = squared_distance(n, qx, qy, qz);
               if (d < found.dist_sq) begin
                  found.dist_sq = d;
                  found.index = INDEX_BITS'(n);
               end
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [23:0] pick_coord(input coord_style_type style);
      case (style)
         COORD_FULL: return 24'($urandom());
         COORD_NEAR: return 24'($urandom_range(0, 8) - 4);
         default: begin
            case ($urandom_range(0, 3))
               0: return C_MIN;
               1: return C_MAX;
               2: return C_NEG1;
               default: return 24'($urandom_range(0, 3));
            endcase
         end
      endcase
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   task automatic send_item(input logic [1:0] kind, input logic [23:0] x,
         input logic [23:0] y, input logic [23:0] z, input bit fixed,
         input nearest_result_type fixed_result);
      int gap;
      nearest_result_type predicted;
      nearest_result_type want_item;
      gap = send_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= kind;
      req_tdata <= {z, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_count++;
      if (search_update(kind, x, y, z, predicted)) begin
         want_item = fixed ? fixed_result : predicted;
         nearest_expected.insert(nearest_expected.size(), want_item);
      end
   endtask

   task automatic send_random(input logic [1:0] kind, input coord_style_type style);
      send_item(kind, pick_coord(style), pick_coord(style), pick_coord(style), 1'b0, '0);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (nearest_expected.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Result side: random stalls, steady stretches, and one long hold-off on request.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!recv_steady) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      nearest_result_type seen;
      nearest_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.index = rsp_tdata[INDEX_BITS-1:0];
         seen.dist_sq = rsp_tdata[INDEX_BITS +: DIST_BITS];
         seen.empty = rsp_tuser;
         if (nearest_expected.size() == 0) begin
            note_mismatch($sformatf("unexpected result index %0d dist %0d empty %0b",
               seen.index, seen.dist_sq, seen.empty));
         end else begin
            want = nearest_expected.pop_front();
            if (seen != want || rsp_tdata[RSP_DATA_BITS-1:INDEX_BITS+DIST_BITS] != '0)
               note_mismatch($sformatf(
                  "got index %0d dist %0d empty %0b pad %h, expected %0d %0d %0b",
                  seen.index, seen.dist_sq, seen.empty,
                  rsp_tdata[RSP_DATA_BITS-1:INDEX_BITS+DIST_BITS],
                  want.index, want.dist_sq, want.empty));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("nearest_point_search: mismatch");
      $finish;
   end

   initial begin
      coord_style_type style;
      int n_points;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_CLEAR;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
            directed_rows[i].z, directed_rows[i].fixed,
            {directed_rows[i].index, directed_rows[i].dist_sq, directed_rows[i].empty});

      // The result side holds off while queries keep coming, so the input must stall.
      hold_request = 1'b1;
      send_steady = 1'b1;
      repeat (3) send_random(KIND_APPEND, COORD_NEAR);
      repeat (8) send_random(KIND_QUERY, COORD_NEAR);
      send_steady = 1'b0;
      wait_drained();

      while (sent_count < ITEM_TARGET - 3) begin
         style = coord_style_type'($urandom_range(0, 2));
         send_steady = ($urandom_range(0, 3) == 0);
         recv_steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 9) < 7) send_random(KIND_CLEAR, style);
            n_points = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                                    : $urandom_range(1, 8);
            repeat (n_points) send_random(KIND_APPEND, style);
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 3) == 0) send_random(KIND_APPEND, style);
               send_random(KIND_QUERY, style);
            end
         end else begin
            repeat ($urandom_range(1, 5)) send_random(2'($urandom_range(0, 3)), COORD_FULL);
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end

      send_steady = 1'b0;
      recv_steady = 1'b0;
      repeat (3) send_random(KIND_QUERY, COORD_FULL);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (nearest_expected.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && nearest_expected.size() == 0)
         $display("nearest_point_search: match");
      else
         $display("nearest_point_search: mismatch");
      $finish;
   end

endmodule

// File: files.f
hdl/nps_pkg.sv
hdl/nps_ram.sv
hdl/nps_front.sv
hdl/nps_back.sv
hdl/nearest_point_search.sv
tb/tb_nearest_point_search.sv
